/* design/wapr_pkg.sv */
// ----------------------------------------------------------------------------
// wapr_pkg
// shared types and constants of the anti-pinch reversal control unit
// ----------------------------------------------------------------------------
`default_nettype none

package wapr_pkg;

	// apb address width: three 32-bit registers at byte offsets 0, 4, 8
	localparam int unsigned AddrW = 4;
	localparam int unsigned DataW = 32;
	localparam int unsigned PosW  = 16;

	localparam logic [PosW-1:0] LockoutTicksReset = 16'd5000;
	localparam logic [1:0]      LockoutThreshold  = 2'd2;
	localparam logic [1:0]      LockoutCountMax   = 2'd3;

	// motor direction codes, code 3 means neither direction
	localparam logic [1:0] DirClosing = 2'd1;
	localparam logic [1:0] DirOpening = 2'd2;

	typedef enum logic {
		OP_STEP = 1'b0,
		OP_TICK = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		REG_REVERSE_DISTANCE = 2'd0,
		REG_LOCKOUT_ENABLE   = 2'd1,
		REG_LOCKOUT_TICKS    = 2'd2
	} reg_idx_t;

	typedef struct packed {
		opcode_t         opcode;
		logic [PosW-1:0] hall_position;
		logic            sample_ready;
		logic            position_valid;
		logic            pinch_result;
		logic [1:0]      motor_direction;
		logic            motor_stopped;
		logic            stop_delay_done;
		logic            in_pinch_zone;
		logic            blocked_up;
		logic            blocked_down;
		logic            at_soft_stop;
	} step_t;

	typedef struct packed {
		logic stop_request;
		logic reverse_request;
		logic pinch_active;
		logic reversing;
		logic protection_off;
		logic keep_awake;
		logic sample_consumed;
		logic detector_reset;
	} result_t;

	typedef struct packed {
		logic [PosW-1:0] reverse_distance;
		logic            lockout_enable;
		logic [PosW-1:0] lockout_ticks;
	} cfg_t;

endpackage

`default_nettype wire

/* design/wapr_step_if.sv */
// ----------------------------------------------------------------------------
// wapr_step_if
// valid/ready channel carrying one input item (tick or control step)
// ----------------------------------------------------------------------------
`default_nettype none

interface wapr_step_if;
	logic            valid;
	logic            ready;
	wapr_pkg::step_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* design/wapr_result_if.sv */
// ----------------------------------------------------------------------------
// wapr_result_if
// valid/ready channel carrying one result item
// ----------------------------------------------------------------------------
`default_nettype none

interface wapr_result_if;
	logic              valid;
	logic              ready;
	wapr_pkg::result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* design/wapr_regs.sv */
// ----------------------------------------------------------------------------
// wapr_regs
// apb configuration registers: reverse distance, lockout enable, lockout load
// ----------------------------------------------------------------------------
`default_nettype none

module wapr_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [wapr_pkg::AddrW-1:0]   paddr,
	input  wire logic [wapr_pkg::DataW-1:0]   pwdata,
	output logic      [wapr_pkg::DataW-1:0]   prdata,
	output logic                              pready,
	output wapr_pkg::cfg_t                    cfg
);

	wapr_pkg::reg_idx_t idx;
	logic               wr_en;

	assign idx    = wapr_pkg::reg_idx_t'(paddr[wapr_pkg::AddrW-1:2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.reverse_distance <= '0;
			cfg.lockout_enable   <= 1'b1;
			cfg.lockout_ticks    <= wapr_pkg::LockoutTicksReset;
		end else if (wr_en) begin
			unique case (idx)
				wapr_pkg::REG_REVERSE_DISTANCE: begin
					cfg.reverse_distance <= pwdata[wapr_pkg::PosW-1:0];
				end
				wapr_pkg::REG_LOCKOUT_ENABLE: begin
					cfg.lockout_enable <= pwdata[0];
				end
				wapr_pkg::REG_LOCKOUT_TICKS: begin
					cfg.lockout_ticks <= pwdata[wapr_pkg::PosW-1:0];
				end
				default: begin
					// unmapped offset, write dropped
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			wapr_pkg::REG_REVERSE_DISTANCE: prdata[wapr_pkg::PosW-1:0] = cfg.reverse_distance;
			wapr_pkg::REG_LOCKOUT_ENABLE:   prdata[0] = cfg.lockout_enable;
			wapr_pkg::REG_LOCKOUT_TICKS:    prdata[wapr_pkg::PosW-1:0] = cfg.lockout_ticks;
			default:                        prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

/* design/wapr_core.sv */
// ----------------------------------------------------------------------------
// wapr_core
// anti-pinch state and the single-pass step logic for one item
// ----------------------------------------------------------------------------
`default_nettype none

module wapr_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             fire,
	input  wire wapr_pkg::step_t  item,
	input  wire wapr_pkg::cfg_t   cfg,
	output wapr_pkg::result_t     result
);

	logic                      ev_q, rev_q, flag_q, stop_q, down_q;
	logic [wapr_pkg::PosW-1:0] target_q, timer_q;
	logic [1:0]                count_q;

	logic                      ev_d, rev_d, flag_d, stop_d, down_d;
	logic [wapr_pkg::PosW-1:0] target_d, timer_d;
	logic [1:0]                count_d;
	logic                      pinch, trigger, awake, consumed, det, past_end;

	always_comb begin
		ev_d     = ev_q;
		rev_d    = rev_q;
		flag_d   = flag_q;
		stop_d   = stop_q;
		down_d   = down_q;
		target_d = target_q;
		timer_d  = timer_q;
		count_d  = count_q;
		pinch    = 1'b0;
		trigger  = 1'b0;
		consumed = 1'b0;
		det      = 1'b0;
		awake    = ev_q;
		past_end = (item.hall_position > target_q) || item.blocked_down || item.at_soft_stop;

		if (item.opcode == wapr_pkg::OP_TICK) begin
			if (timer_q != '0) begin
				timer_d = timer_q - 16'd1;
			end
		end else begin
			// lockout flag from timer and event count
			if (timer_q != '0) begin
				if (count_q >= wapr_pkg::LockoutThreshold) begin
					flag_d = !item.blocked_up;
					if (item.blocked_up) begin
						count_d = '0;
					end
				end
			end else begin
				flag_d  = 1'b0;
				count_d = '0;
			end

			// sample evaluation
			if (item.sample_ready) begin
				pinch    = (item.motor_direction == wapr_pkg::DirClosing) &&
				           item.position_valid && item.pinch_result;
				consumed = 1'b1;
			end

			// stop latch
			trigger = item.blocked_up || pinch;
			det     = trigger || item.motor_stopped;
			if (trigger && item.in_pinch_zone && !flag_d && !ev_q) begin
				ev_d   = 1'b1;
				stop_d = 1'b1;
			end
			awake = ev_d;

			// reversal
			if (ev_d) begin
				if (!rev_q) begin
					if (item.motor_stopped && item.stop_delay_done) begin
						target_d = item.hall_position + cfg.reverse_distance;
						rev_d    = 1'b1;
						stop_d   = 1'b0;
						down_d   = 1'b1;
					end else begin
						stop_d = 1'b1;
					end
				end else if (past_end) begin
					stop_d = 1'b1;
					down_d = 1'b0;
					ev_d   = 1'b0;
					rev_d  = 1'b0;
					if (cfg.lockout_enable) begin
						timer_d = cfg.lockout_ticks;
						if (count_d != wapr_pkg::LockoutCountMax) begin
							count_d = count_d + 2'd1;
						end
					end
				end else if (item.motor_direction != wapr_pkg::DirOpening) begin
					// early end, held requests clear on a later step
					ev_d  = 1'b0;
					rev_d = 1'b0;
				end
			end else begin
				rev_d  = 1'b0;
				down_d = 1'b0;
				stop_d = 1'b0;
			end
		end

		result.stop_request    = stop_d;
		result.reverse_request = down_d;
		result.pinch_active    = ev_d;
		result.reversing       = rev_d;
		result.protection_off  = flag_d;
		result.keep_awake      = awake;
		result.sample_consumed = consumed;
		result.detector_reset  = det;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_q     <= 1'b0;
			rev_q    <= 1'b0;
			flag_q   <= 1'b0;
			stop_q   <= 1'b0;
			down_q   <= 1'b0;
			target_q <= '0;
			timer_q  <= '0;
			count_q  <= '0;
		end else if (fire) begin
			ev_q     <= ev_d;
			rev_q    <= rev_d;
			flag_q   <= flag_d;
			stop_q   <= stop_d;
			down_q   <= down_d;
			target_q <= target_d;
			timer_q  <= timer_d;
			count_q  <= count_d;
		end
	end

	// reversal only ever runs inside a latched event
	a_rev_in_event: assert property (@(posedge clk) disable iff (!arst_n)
		rev_q |-> ev_q)
		else $error("reversing without a latched event");

	// the lockout timer only reloads when a reversal completes
	a_timer_reload: assert property (@(posedge clk) disable iff (!arst_n)
		(timer_q > $past(timer_q)) |-> ($past(rev_q) && !rev_q && $past(fire)))
		else $error("lockout timer loaded outside reversal end");

	// a tick never raises the timer or touches the event flags
	a_tick_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item.opcode == wapr_pkg::OP_TICK) |=>
			(timer_q <= $past(timer_q) && $stable(ev_q) && $stable(rev_q)))
		else $error("tick changed more than the lockout timer");

endmodule

`default_nettype wire

/* design/window_antipinch_reverse_control_unit.sv */
// ----------------------------------------------------------------------------
// window_antipinch_reverse_control_unit
// an item is registered in stage 1 on transfer, and its result is registered in stage 2
// throughput: one item per cycle unless the output stalls; the input register
//   and result register let in a new transfer while a finished result waits
// reset: arst_n clears the anti-pinch state and both stage valids at once,
//   the registers return to distance 0, lockout enabled, 5000 ticks
// ----------------------------------------------------------------------------
`default_nettype none

module window_antipinch_reverse_control_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	wapr_step_if.sink                        step,
	wapr_result_if.source                    result,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [wapr_pkg::AddrW-1:0]  paddr,
	input  wire logic [wapr_pkg::DataW-1:0]  pwdata,
	output logic      [wapr_pkg::DataW-1:0]  prdata,
	output logic                             pready
);

	// stage 1: registered input item
	logic              valid_s1;
	wapr_pkg::step_t   item_s1;

	// stage 2: registered result waiting for its transfer
	logic              valid_s2;
	wapr_pkg::result_t res_s2;

	wapr_pkg::cfg_t    cfg;
	wapr_pkg::result_t core_res;
	logic              in_xfer;
	logic              advance;

	// user must change configuration only while idle; unenforced, core reads it directly
	wapr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// stage 1 moves on when the result slot is free or being drained
	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign step.ready = !valid_s1 || advance;
	assign in_xfer    = step.valid && step.ready;

	// state update and result for the item in stage 1, in one pass
	wapr_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_xfer) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1 <= step.payload;
		end
		if (advance) begin
			res_s2 <= core_res;
		end
	end

	assign result.valid   = valid_s2;
	assign result.payload = res_s2;

endmodule

`default_nettype wire
